FILE: sv/minmax_contrast_stretch_defines.svh
// Assertion macros shared by the checker of the contrast stretch block.
`ifndef MINMAX_CONTRAST_STRETCH_DEFINES_SVH
`define MINMAX_CONTRAST_STRETCH_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// The consequent must hold in the cycle after the antecedent.
`define MCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

FILE: sv/mcs_pkg.sv
package mcs_pkg;

  localparam int PIXEL_BITS_DEF = 16;
  localparam int VALUE_BITS = 16;
  localparam logic [VALUE_BITS-1:0] OUT_MAX_RESET = 16'd255;

  typedef struct packed {
    logic accept;
    logic load_direct;
    logic mul;
    logic step;
    logic load_div;
  } cmd_t;

  typedef struct packed {
    logic scale;
    logic direct;
    logic step_last;
  } status_t;

endpackage

FILE: sv/minmax_contrast_stretch.sv
// Min-max contrast stretch. Stream the image once with in_op low to measure its extremes, then
// again with in_op high; each scale transaction returns floor(out_max*(pixel-min)/(max-min)),
// the pixel itself when out_max is zero, and zero for a flat image. A measure transaction and
// a scale transaction that hits a clamp case finish at acceptance. Any other scale transaction
// passes acceptance, the 16 by PIXEL_BITS multiplier, 16 iterations of the restoring divider at
// one quotient bit per cycle, and the load of the output register, which waits until it is free
// or being emptied. The next transaction is taken once the block is idle and the output register
// is free or being emptied. The out_max register may be rewritten only while the block is idle.
module minmax_contrast_stretch #(
  parameter int PIXEL_BITS = mcs_pkg::PIXEL_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [15:0] in_pixel,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_value,
  output logic        out_last_res
);

  mcs_pkg::cmd_t    cmd;
  mcs_pkg::status_t st;

  assign cfg_ready = 1'b1;

  mcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  mcs_dp #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .in_op        (in_op),
    .in_pixel     (in_pixel),
    .in_last      (in_last),
    .cmd          (cmd),
    .st           (st),
    .out_value    (out_value),
    .out_last_res (out_last_res)
  );

endmodule

FILE: sv/mcs_ctrl.sv
module mcs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  mcs_pkg::status_t st,
  output mcs_pkg::cmd_t   cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !slot_free;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.accept = 1'b1;
          if (st.scale) begin
            if (st.direct) begin
              cmd.load_direct = 1'b1;
              out_valid_nxt   = 1'b1;
            end else begin
              state_nxt = S_MUL;
            end
          end
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (st.step_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.load_div  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: sv/mcs_dp.sv
module mcs_dp #(
  parameter int PIXEL_BITS = mcs_pkg::PIXEL_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mcs_pkg::VALUE_BITS-1:0] cfg_data,
  input  logic                           in_op,
  input  logic [15:0]                    in_pixel,
  input  logic                           in_last,
  input  mcs_pkg::cmd_t                  cmd,
  output mcs_pkg::status_t               st,
  output logic [mcs_pkg::VALUE_BITS-1:0] out_value,
  output logic                           out_last_res
);

  localparam int VB        = mcs_pkg::VALUE_BITS;
  localparam int PB        = PIXEL_BITS;
  localparam int PROD_BITS = VB + PB;
  localparam int CNT_BITS  = $clog2(VB);

  logic [VB-1:0]       out_max_r;
  logic [PB-1:0]       min_r, max_r;
  logic                started_r;
  logic [PB-1:0]       off_r, den_r, rem_r;
  logic [VB-1:0]       quo_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic                last_r;
  logic [VB-1:0]       value_r;
  logic                last_res_r;

  logic [PB-1:0]        pix;
  logic                 direct;
  logic [VB-1:0]        direct_val;
  logic [PROD_BITS-1:0] prod;
  logic [PB:0]          trial;
  logic                 ge;

  assign pix   = in_pixel[PB-1:0];
  assign prod  = PROD_BITS'(out_max_r) * PROD_BITS'(off_r);
  assign trial = {rem_r, quo_r[VB-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    direct     = 1'b1;
    direct_val = '0;
    if (out_max_r == '0) begin
      direct_val = VB'(pix);
    end else if (max_r <= min_r) begin
      direct_val = '0;
    end else if (pix <= min_r) begin
      direct_val = '0;
    end else if (pix >= max_r) begin
      direct_val = out_max_r;
    end else begin
      direct = 1'b0;
    end
  end

  assign st.scale     = in_op;
  assign st.direct    = direct;
  assign st.step_last = cnt_r == CNT_BITS'(VB - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_max_r <= mcs_pkg::OUT_MAX_RESET;
      min_r     <= '0;
      max_r     <= '0;
      started_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        out_max_r <= cfg_data;
      end
      if (cmd.accept) begin
        if (!in_op) begin
          if (!started_r) begin
            min_r <= pix;
            max_r <= pix;
          end else if (pix > max_r) begin
            max_r <= pix;
          end else if (pix < min_r) begin
            min_r <= pix;
          end
          started_r <= !in_last;
        end else begin
          started_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && in_op) begin
      off_r  <= pix - min_r;
      den_r  <= max_r - min_r;
      last_r <= in_last;
    end
    if (cmd.mul) begin
      rem_r <= prod[PROD_BITS-1:VB];
      quo_r <= prod[VB-1:0];
      cnt_r <= '0;
    end
    if (cmd.step) begin
      rem_r <= ge ? PB'(trial - {1'b0, den_r}) : trial[PB-1:0];
      quo_r <= {quo_r[VB-2:0], ge};
      cnt_r <= cnt_r + CNT_BITS'(1);
    end
    if (cmd.load_direct) begin
      value_r    <= direct_val;
      last_res_r <= in_last;
    end
    if (cmd.load_div) begin
      value_r    <= quo_r;
      last_res_r <= last_r;
    end
  end

  assign out_value    = value_r;
  assign out_last_res = last_res_r;

endmodule

FILE: sv/mcs_checker.sv
`include "minmax_contrast_stretch_defines.svh"

module mcs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_op,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_value,
  input logic        out_last_res
);

  logic in_acc;
  logic out_full;

  assign in_acc   = in_valid && !in_stall;
  assign out_full = out_valid && out_stall;

  `MCS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_full, out_valid && $stable(out_value) && $stable(out_last_res))
  `MCS_ASSERT_NOW(a_full_stalls_input, clk, rst_n, out_full, in_stall)
  `MCS_ASSERT_NEXT(a_scale_busy, clk, rst_n, in_acc && in_op, out_valid || in_stall)
  `MCS_ASSERT_NEXT(a_measure_silent, clk, rst_n, in_acc && !in_op && !out_valid, !out_valid)

endmodule

bind minmax_contrast_stretch mcs_checker u_mcs_checker (.*);
